// File: hdl/gbg_pkg.sv
package gbg_pkg;

    // Default grid size; the top level takes these as parameter defaults.
    localparam int unsigned MAX_COLUMNS = 256;
    localparam int unsigned MAX_ROWS    = 256;

    // Fixed arithmetic widths.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CELL_W = 16;
    localparam int unsigned FRAC_W = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_INV_X     = 3'd2,
        REG_INV_Y     = 3'd3,
        REG_COLUMNS   = 3'd4,
        REG_ROWS      = 3'd5
    } t_reg_idx;

    // Result of locating a query along one axis.
    typedef struct packed {
        logic              hit;
        logic [CELL_W-1:0] idx;
        logic [FRAC_W-1:0] frac;
    } t_axis_loc;

endpackage

// File: hdl/gbg_locate.sv
module gbg_locate #(
    parameter int unsigned CW = 9
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [31:0]         i_query,
    input  logic [31:0]         i_origin,
    input  logic [31:0]         i_inv,
    input  logic [CW-1:0]       i_count,
    output gbg_pkg::t_axis_loc  o_loc
);

    logic signed [32:0] r_diff;
    logic        [63:0] r_prod;
    logic               r_neg;
    logic        [32:0] w_mag;
    logic        [16:0] w_next;

    // Offset from the origin, then the scaled offset in Q32.32.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= $signed({i_query[31], i_query}) - $signed({i_origin[31], i_origin});
            r_neg  <= r_diff[32];
            r_prod <= 64'(w_mag * {1'b0, i_inv});
        end
    end

    assign w_mag  = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
    assign w_next = {1'b0, r_prod[63:48]} + 17'd1;

    // A negative offset that scales to zero still lands in cell zero.
    always_comb begin
        o_loc.idx  = r_prod[63:48];
        o_loc.frac = r_prod[47:32];
        o_loc.hit  = (17'(i_count) >= 17'd2) && !(r_neg && (r_prod != 64'd0))
                     && (w_next < 17'(i_count));
    end

endmodule

// File: hdl/gbg_bank.sv
module gbg_bank #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: hdl/grid_bilinear_gradient_unit.sv
// Bilinear elevation and minus-gradient on a uniform grid of stored samples.
//
// Input channel (i_valid / o_stall): one transfer per item. A load item writes
// one Q16.16 sample into the elevation store and produces no result. An evaluate
// item carries a query position and produces exactly one result on the output
// channel (o_valid / i_stall): the inside flag, the interpolated height and the
// two slopes, all zero when the position falls outside the grid.
// The store is split into four banks by column and row parity, so the four
// corners of a cell are read in the same cycle and a new item is taken every
// cycle while o_stall is low; throughput is one item per cycle, limited by the
// single read port of each of the four banks.
// Loads write the banks at the same pipeline stage where evaluations read them,
// so items always see the store in the order they were accepted.
// When the receiver stalls, a finished result waits in the output register and
// one more lands in a skid register; only then does o_stall rise and the whole
// pipeline hold. Reset clears the pipeline and sets the configuration
// registers to their defaults; the store holds no defined value until written
// and needs no clearing pass. Configuration registers sit on an APB-style port
// at byte addresses 4*i and may be written only while no evaluation is in flight.
module grid_bilinear_gradient_unit #(
    parameter int unsigned MAX_COLUMNS = gbg_pkg::MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = gbg_pkg::MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_load_column,
    input  logic [7:0]  i_load_row,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_query_x,
    input  logic [31:0] i_query_y,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_inside_res,
    output logic [31:0] o_height,
    output logic [31:0] o_slope_x,
    output logic [31:0] o_slope_y,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CWC    = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned CWR    = $clog2(MAX_ROWS + 1);
    localparam int unsigned HALF_C = (MAX_COLUMNS + 1) / 2;
    localparam int unsigned HALF_R = (MAX_ROWS + 1) / 2;
    localparam int unsigned BDEPTH = HALF_C * HALF_R;
    localparam int unsigned BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

    // Configuration registers.
    logic [31:0] r_origin_x, r_origin_y, r_inv_x, r_inv_y;
    logic [8:0]  r_cols, r_rows;
    logic [CWC-1:0] w_cols;
    logic [CWR-1:0] w_rows;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_inv_x    <= 32'h0001_0000;
            r_inv_y    <= 32'h0001_0000;
            r_cols     <= 9'd256;
            r_rows     <= 9'd256;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                gbg_pkg::REG_ORIGIN_X: r_origin_x <= pwdata;
                gbg_pkg::REG_ORIGIN_Y: r_origin_y <= pwdata;
                gbg_pkg::REG_INV_X:    r_inv_x    <= pwdata;
                gbg_pkg::REG_INV_Y:    r_inv_y    <= pwdata;
                gbg_pkg::REG_COLUMNS:  r_cols     <= pwdata[8:0];
                gbg_pkg::REG_ROWS:     r_rows     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gbg_pkg::REG_ORIGIN_X: prdata = r_origin_x;
            gbg_pkg::REG_ORIGIN_Y: prdata = r_origin_y;
            gbg_pkg::REG_INV_X:    prdata = r_inv_x;
            gbg_pkg::REG_INV_Y:    prdata = r_inv_y;
            gbg_pkg::REG_COLUMNS:  prdata = {23'd0, r_cols};
            gbg_pkg::REG_ROWS:     prdata = {23'd0, r_rows};
            default:               prdata = '0;
        endcase
    end

    // Counts above the store size are clamped to it.
    always_comb begin
        if (32'(r_cols) > 32'(MAX_COLUMNS)) begin
            w_cols = CWC'(MAX_COLUMNS);
        end else begin
            w_cols = CWC'(r_cols);
        end
        if (32'(r_rows) > 32'(MAX_ROWS)) begin
            w_rows = CWR'(MAX_ROWS);
        end else begin
            w_rows = CWR'(r_rows);
        end
    end

    // Pipeline advance: the whole pipe holds only while the skid register is full.
    logic r_skid_valid, r_out_valid;
    logic w_en;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;

    // Stage 1: registered input.
    logic        r_s1_valid, r_s1_op;
    logic [7:0]  r_s1_col, r_s1_row;
    logic [31:0] r_s1_val, r_s1_qx, r_s1_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op  <= i_operation;
            r_s1_col <= i_load_column;
            r_s1_row <= i_load_row;
            r_s1_val <= i_sample_value;
            r_s1_qx  <= i_query_x;
            r_s1_qy  <= i_query_y;
        end
    end

    // Stages 2 and 3: cell location in the locate units; loads ride alongside.
    gbg_pkg::t_axis_loc w_loc_x, w_loc_y;

    gbg_locate #(.CW(CWC)) u_loc_x (
        .i_clk(i_clk), .i_en(w_en), .i_query(r_s1_qx), .i_origin(r_origin_x),
        .i_inv(r_inv_x), .i_count(w_cols), .o_loc(w_loc_x)
    );

    gbg_locate #(.CW(CWR)) u_loc_y (
        .i_clk(i_clk), .i_en(w_en), .i_query(r_s1_qy), .i_origin(r_origin_y),
        .i_inv(r_inv_y), .i_count(w_rows), .o_loc(w_loc_y)
    );

    logic        r_s2_valid, r_s2_op, r_s3_valid, r_s3_op;
    logic [7:0]  r_s2_col, r_s2_row, r_s3_col, r_s3_row;
    logic [31:0] r_s2_val, r_s3_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op  <= r_s1_op;
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
            r_s2_val <= r_s1_val;
            r_s3_op  <= r_s2_op;
            r_s3_col <= r_s2_col;
            r_s3_row <= r_s2_row;
            r_s3_val <= r_s2_val;
        end
    end

    // Bank access. Bank k holds column parity k[1] and row parity k[0].
    logic w_s3_eval, w_s3_inside, w_load_ok;
    logic [31:0] w_bank_rd [4];

    assign w_s3_eval   = r_s3_valid && (r_s3_op == gbg_pkg::OP_EVAL);
    assign w_s3_inside = w_loc_x.hit && w_loc_y.hit;
    assign w_load_ok   = w_en && r_s3_valid && (r_s3_op == gbg_pkg::OP_LOAD)
                         && (32'(r_s3_col) < 32'(MAX_COLUMNS))
                         && (32'(r_s3_row) < 32'(MAX_ROWS));

    for (genvar k = 0; k < 4; k++) begin : g_bank
        localparam logic CP = 1'((k >> 1) & 1);
        localparam logic RP = 1'(k & 1);
        logic [15:0]  w_rcol, w_rrow;
        logic [BAW-1:0] w_raddr, w_waddr;
        logic w_we;

        always_comb begin
            w_rcol = (w_loc_x.idx[0] == CP) ? w_loc_x.idx : w_loc_x.idx + 16'd1;
            w_rrow = (w_loc_y.idx[0] == RP) ? w_loc_y.idx : w_loc_y.idx + 16'd1;
            if (w_s3_inside) begin
                w_raddr = BAW'(32'(w_rrow >> 1) * HALF_C + 32'(w_rcol >> 1));
            end else begin
                w_raddr = '0;
            end
            w_waddr = BAW'(32'(r_s3_row >> 1) * HALF_C + 32'(r_s3_col >> 1));
            w_we    = w_load_ok && (r_s3_col[0] == CP) && (r_s3_row[0] == RP);
        end

        gbg_bank #(.DEPTH(BDEPTH), .AW(BAW)) u_bank (
            .i_clk(i_clk), .i_en(w_en), .i_we(w_we), .i_waddr(w_waddr),
            .i_wdata(r_s3_val), .i_raddr(w_raddr), .o_rdata(w_bank_rd[k])
        );
    end

    // Stage 4: corner data out of the banks.
    logic        r_s4_valid, r_s4_inside, r_s4_pi, r_s4_pj;
    logic [15:0] r_s4_a, r_s4_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= w_s3_eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_inside <= w_s3_inside;
            r_s4_pi     <= w_loc_x.idx[0];
            r_s4_pj     <= w_loc_y.idx[0];
            r_s4_a      <= w_loc_x.frac;
            r_s4_b      <= w_loc_y.frac;
        end
    end

    // Corners A=(i,j), B=(i,j+1), C=(i+1,j+1), D=(i+1,j) by bank parity.
    logic signed [31:0] w_ca, w_cb, w_cc, w_cd;
    logic [16:0] w_oma, w_omb;

    always_comb begin
        w_ca  = w_bank_rd[{r_s4_pi, r_s4_pj}];
        w_cb  = w_bank_rd[{r_s4_pi, !r_s4_pj}];
        w_cc  = w_bank_rd[{!r_s4_pi, !r_s4_pj}];
        w_cd  = w_bank_rd[{!r_s4_pi, r_s4_pj}];
        w_oma = 17'h10000 - {1'b0, r_s4_a};
        w_omb = 17'h10000 - {1'b0, r_s4_b};
    end

    // Stage 5: weights, corner differences and fraction-scaled spacings.
    logic               r_s5_valid, r_s5_inside;
    logic        [32:0] r_s5_wa, r_s5_wb, r_s5_wc, r_s5_wd;
    logic signed [31:0] r_s5_ca, r_s5_cb, r_s5_cc, r_s5_cd;
    logic signed [34:0] r_s5_g;
    logic signed [32:0] r_s5_dx, r_s5_dy;
    logic        [47:0] r_s5_fix, r_s5_fiy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_inside <= r_s4_inside;
            r_s5_wa <= 33'(w_oma * w_omb);
            r_s5_wb <= 33'(w_oma * {1'b0, r_s4_b});
            r_s5_wc <= 33'({1'b0, r_s4_a} * {1'b0, r_s4_b});
            r_s5_wd <= 33'({1'b0, r_s4_a} * w_omb);
            r_s5_ca <= w_ca;
            r_s5_cb <= w_cb;
            r_s5_cc <= w_cc;
            r_s5_cd <= w_cd;
            r_s5_g  <= 35'(w_ca) + 35'(w_cc) - 35'(w_cb) - 35'(w_cd);
            r_s5_dx <= 33'(w_cd) - 33'(w_ca);
            r_s5_dy <= 33'(w_cb) - 33'(w_ca);
            r_s5_fix <= r_s4_a * r_inv_y;
            r_s5_fiy <= r_s4_b * r_inv_x;
        end
    end

    // Stage 6: products; the 48-bit scale factor is split in two halves.
    logic               r_s6_valid, r_s6_inside;
    logic signed [65:0] r_s6_pa, r_s6_pb, r_s6_pc, r_s6_pd;
    logic signed [65:0] r_s6_t1x, r_s6_t1y;
    logic signed [59:0] r_s6_gxl, r_s6_gxh, r_s6_gyl, r_s6_gyh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (w_en) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_inside <= r_s5_inside;
            r_s6_pa  <= $signed({1'b0, r_s5_wa}) * r_s5_ca;
            r_s6_pb  <= $signed({1'b0, r_s5_wb}) * r_s5_cb;
            r_s6_pc  <= $signed({1'b0, r_s5_wc}) * r_s5_cc;
            r_s6_pd  <= $signed({1'b0, r_s5_wd}) * r_s5_cd;
            r_s6_t1x <= r_s5_dx * $signed({1'b0, r_inv_x});
            r_s6_t1y <= r_s5_dy * $signed({1'b0, r_inv_y});
            r_s6_gxl <= r_s5_g * $signed({1'b0, r_s5_fix[23:0]});
            r_s6_gxh <= r_s5_g * $signed({1'b0, r_s5_fix[47:24]});
            r_s6_gyl <= r_s5_g * $signed({1'b0, r_s5_fiy[23:0]});
            r_s6_gyh <= r_s5_g * $signed({1'b0, r_s5_fiy[47:24]});
        end
    end

    // Stage 7: height sum and rounding; gradient cross terms recombined.
    logic signed [67:0] w_hsum;
    logic signed [67:0] w_hrnd;

    assign w_hsum = 68'(r_s6_pa) + 68'(r_s6_pb) + 68'(r_s6_pc) + 68'(r_s6_pd);
    assign w_hrnd = w_hsum + 68'sh8000_0000;

    logic               r_s7_valid, r_s7_inside;
    logic        [31:0] r_s7_height;
    logic signed [65:0] r_s7_t1x, r_s7_t1y;
    logic signed [83:0] r_s7_t2x, r_s7_t2y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (w_en) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_inside <= r_s6_inside;
            r_s7_height <= w_hrnd[63:32];
            r_s7_t1x    <= r_s6_t1x;
            r_s7_t1y    <= r_s6_t1y;
            r_s7_t2x    <= (84'(r_s6_gxh) <<< 24) + 84'(r_s6_gxl);
            r_s7_t2y    <= (84'(r_s6_gyh) <<< 24) + 84'(r_s6_gyl);
        end
    end

    // Negate, round half up from Q48 to Q16.16 and saturate.
    function automatic logic [31:0] slope_round(input logic signed [65:0] t1,
                                                input logic signed [83:0] t2);
        logic signed [84:0] s;
        logic signed [52:0] q;
        s = 85'sh8000_0000 - ((85'(t1) <<< 16) + 85'(t2));
        q = 53'(s >>> 32);
        if (q > 53'sh7FFF_FFFF) begin
            slope_round = 32'h7FFF_FFFF;
        end else if (q < -53'sh8000_0000) begin
            slope_round = 32'h8000_0000;
        end else begin
            slope_round = q[31:0];
        end
    endfunction

    logic [31:0] w_sx, w_sy;

    assign w_sx = slope_round(r_s7_t1x, r_s7_t2x);
    assign w_sy = slope_round(r_s7_t1y, r_s7_t2y);

    // Output register with one skid entry behind it.
    logic        w_arrive, w_out_free;
    logic        r_skid_inside;
    logic [31:0] r_skid_height, r_skid_sx, r_skid_sy;
    logic [31:0] w_new_height, w_new_sx, w_new_sy;

    assign w_arrive     = w_en && r_s7_valid;
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_new_height = r_s7_inside ? r_s7_height : '0;
    assign w_new_sx     = r_s7_inside ? w_sx : '0;
    assign w_new_sy     = r_s7_inside ? w_sy : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (w_arrive && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_arrive) begin
                r_skid_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (w_arrive && w_out_free) begin
            o_inside_res <= r_s7_inside;
            o_height     <= w_new_height;
            o_slope_x    <= w_new_sx;
            o_slope_y    <= w_new_sy;
        end else if (w_arrive) begin
            r_skid_inside <= r_s7_inside;
            r_skid_height <= w_new_height;
            r_skid_sx     <= w_new_sx;
            r_skid_sy     <= w_new_sy;
        end else if (w_out_free && r_skid_valid) begin
            o_inside_res <= r_skid_inside;
            o_height     <= r_skid_height;
            o_slope_x    <= r_skid_sx;
            o_slope_y    <= r_skid_sy;
        end
    end

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result with the output register empty");

    // A result outside the grid carries only zeros.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_inside_res) |->
            (o_height == '0 && o_slope_x == '0 && o_slope_y == '0))
        else $error("outside result carries nonzero values");

    // While the pipe holds, the last stage keeps its item.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_s7_valid) |=> r_s7_valid)
        else $error("item lost from last stage while pipeline held");

    // No bank write while the pipeline is held.
    a_no_write_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> !w_load_ok)
        else $error("bank write during pipeline hold");

endmodule

// File: bench/grid_bilinear_gradient_checker.sv
module grid_bilinear_gradient_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_load_column,
    input  logic [7:0]  i_load_row,
    input  logic [31:0] i_sample_value,
    input  logic [31:0] i_query_x,
    input  logic [31:0] i_query_y,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_inside_res,
    input  logic [31:0] o_height,
    input  logic [31:0] o_slope_x,
    input  logic [31:0] o_slope_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic        in_grid;
        logic [31:0] height;
        logic [31:0] slope_x;
        logic [31:0] slope_y;
    } t_grid_result;

    localparam wide_t SAT_HI = 2147483647;
    localparam wide_t SAT_LO = -SAT_HI - 1;

    logic [31:0]  elevation [0:65535];
    logic [31:0]  org_x, org_y, inv_x, inv_y;
    logic [8:0]   n_cols, n_rows;
    t_grid_result expected_results[$];

    assign pending = expected_results.size();

    function automatic bit locate_axis(input logic [31:0] q, input logic [31:0] org,
                                       input logic [31:0] inv, input int unsigned count,
                                       output int unsigned slot, output logic [15:0] frac);
        longint          diff;
        longint unsigned prod;
        slot = 0;
        frac = '0;
        if (count < 2) return 0;
        diff = longint'($signed(q)) - longint'($signed(org));
        if (diff < 0) begin
            prod = longint'(-diff) * longint'({32'b0, inv});
            if (prod != 0) return 0;
        end else begin
            prod = longint'(diff) * longint'({32'b0, inv});
        end
        if ((prod >> 48) + 1 >= count) return 0;
        slot = int'(prod >> 48);
        frac = 16'(prod >> 32);
        return 1;
    endfunction

    // Rounds a Q48 value half up to Q16.16 and clips it to 32 signed bits.
    function automatic logic [31:0] round_clip(input wide_t v);
        wide_t r;
        r = (v + (wide_t'(1) <<< 31)) >>> 32;
        if (r > SAT_HI) return 32'h7FFF_FFFF;
        if (r < SAT_LO) return 32'h8000_0000;
        return r[31:0];
    endfunction

    function automatic logic [31:0] neg_slope(input longint diff, input logic [31:0] inv_a,
                                              input logic [15:0] frac,
                                              input logic [31:0] inv_b, input longint g);
        wide_t d, ia, f, ib, gw, t1, t2;
        d  = diff;
        ia = inv_a;
        f  = frac;
        ib = inv_b;
        gw = g;
        t1 = (d * ia) <<< 16;
        t2 = gw * f * ib;
        return round_clip(-(t1 + t2));
    endfunction

    function automatic t_grid_result evaluate(input logic [31:0] qx, input logic [31:0] qy);
        t_grid_result res;
        int unsigned  ci, rj, cc, rc;
        logic [15:0]  a, b;
        longint       ca, cb, cc_, cd, g;
        wide_t        wa, wb, wc, wd, sum;
        res = '0;
        cc = (n_cols > 256) ? 256 : n_cols;
        rc = (n_rows > 256) ? 256 : n_rows;
        if (!locate_axis(qx, org_x, inv_x, cc, ci, a) ||
            !locate_axis(qy, org_y, inv_y, rc, rj, b))
            return res;
        ca  = longint'($signed(elevation[rj * 256 + ci]));
        cb  = longint'($signed(elevation[(rj + 1) * 256 + ci]));
        cc_ = longint'($signed(elevation[(rj + 1) * 256 + ci + 1]));
        cd  = longint'($signed(elevation[rj * 256 + ci + 1]));
        wa  = wide_t'(65536 - a) * wide_t'(65536 - b);
        wb  = wide_t'(65536 - a) * wide_t'(b);
        wc  = wide_t'(a) * wide_t'(b);
        wd  = wide_t'(a) * wide_t'(65536 - b);
        sum = wa * wide_t'(ca) + wb * wide_t'(cb) + wc * wide_t'(cc_) + wd * wide_t'(cd);
        g   = ca + cc_ - cb - cd;
        res.in_grid = 1'b1;
        res.height  = 32'((sum + (wide_t'(1) <<< 31)) >>> 32);
        res.slope_x = neg_slope(cd - ca, inv_x, a, inv_y, g);
        res.slope_y = neg_slope(cb - ca, inv_y, b, inv_x, g);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_grid_result got, want;
        if (!i_rst_n) begin
            org_x      <= '0;
            org_y      <= '0;
            inv_x      <= 32'd65536;
            inv_y      <= 32'd65536;
            n_cols     <= 9'd256;
            n_rows     <= 9'd256;
            mismatches <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (gbg_pkg::t_reg_idx'(paddr[4:2]))
                    gbg_pkg::REG_ORIGIN_X: org_x  <= pwdata;
                    gbg_pkg::REG_ORIGIN_Y: org_y  <= pwdata;
                    gbg_pkg::REG_INV_X:    inv_x  <= pwdata;
                    gbg_pkg::REG_INV_Y:    inv_y  <= pwdata;
                    gbg_pkg::REG_COLUMNS:  n_cols <= pwdata[8:0];
                    gbg_pkg::REG_ROWS:     n_rows <= pwdata[8:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                if (gbg_pkg::t_op'(i_operation) == gbg_pkg::OP_LOAD)
                    elevation[{i_load_row, i_load_column}] <= i_sample_value;
                else
                    expected_results.push_back(evaluate(i_query_x, i_query_y));
            end
            if (o_valid && !i_stall) begin
                got = {o_inside_res, o_height, o_slope_x, o_slope_y};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("Unexpected result transfer: inside %0b height %h", got.in_grid,
                                 got.height);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (mismatches < 10)
                            $display("Mismatch: expected %0b %h %h %h, got %0b %h %h %h",
                                     want.in_grid, want.height, want.slope_x, want.slope_y,
                                     got.in_grid, got.height, got.slope_x, got.slope_y);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/grid_bilinear_gradient_unit_test.sv
module grid_bilinear_gradient_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 125;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [7:0]  i_load_column = '0;
    logic [7:0]  i_load_row = '0;
    logic [31:0] i_sample_value = '0;
    logic [31:0] i_query_x = '0;
    logic [31:0] i_query_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_inside_res;
    logic [31:0] o_height, o_slope_x, o_slope_y;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches, pending;

    // The bench keeps its own view of the settings and of which store entries hold
    // data, so that no evaluation ever reads a corner that was never loaded.
    logic [31:0] cfg_ox = '0, cfg_oy = '0, cfg_ix = 32'd65536, cfg_iy = 32'd65536;
    int unsigned cfg_cols = 256, cfg_rows = 256;
    bit          loaded [0:65535];
    bit          quiet = 1'b0;
    int          idle_cycles = 0;

    grid_bilinear_gradient_unit dut (.*);

    grid_bilinear_gradient_checker checker_i (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Most gaps are short; a few are long, and during quiet stretches there are none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The receiver stalls at random, independently of the sender.
    initial begin
        @(posedge i_rst_n);
        forever begin
            int n;
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // The watchdog ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** grid_bilinear_gradient_unit: FAILED **");
            $finish;
        end
    end

    // Presents one item and returns right after the edge at which it was accepted.
    // A gap lowers valid first; back-to-back items keep valid high throughout.
    task automatic send_item(input gbg_pkg::t_op op, input logic [7:0] col,
                             input logic [7:0] row, input logic [31:0] val,
                             input logic [31:0] qx, input logic [31:0] qy);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_load_column  <= col;
        i_load_row     <= row;
        i_sample_value <= val;
        i_query_x      <= qx;
        i_query_y      <= qy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_sample(input logic [7:0] col, input logic [7:0] row,
                               input logic [31:0] val);
        loaded[{row, col}] = 1'b1;
        send_item(gbg_pkg::OP_LOAD, col, row, val, $urandom, $urandom);
    endtask

    task automatic evaluate_at(input logic [31:0] qx, input logic [31:0] qy);
        send_item(gbg_pkg::OP_EVAL, 8'($urandom), 8'($urandom), $urandom, qx, qy);
    endtask

    // Locates a query along one axis the way the block does, for stimulus shaping.
    function automatic bit axis_cell(input logic [31:0] q, input logic [31:0] org,
                                     input logic [31:0] inv, input int unsigned count,
                                     output int unsigned slot);
        longint          diff;
        longint unsigned prod;
        slot = 0;
        if (count > 256) count = 256;
        if (count < 2) return 0;
        diff = longint'($signed(q)) - longint'($signed(org));
        prod = (diff < 0) ? longint'(-diff) * longint'({32'b0, inv})
                          : longint'(diff) * longint'({32'b0, inv});
        if (diff < 0 && prod != 0) return 0;
        if ((prod >> 48) + 1 >= count) return 0;
        slot = int'(prod >> 48);
        return 1;
    endfunction

    // A query is safe when it is outside or all four corners of its cell hold data.
    function automatic bit safe_query(input logic [31:0] qx, input logic [31:0] qy);
        int unsigned ci, rj;
        if (!axis_cell(qx, cfg_ox, cfg_ix, cfg_cols, ci)) return 1;
        if (!axis_cell(qy, cfg_oy, cfg_iy, cfg_rows, rj)) return 1;
        return loaded[rj * 256 + ci] && loaded[(rj + 1) * 256 + ci]
            && loaded[(rj + 1) * 256 + ci + 1] && loaded[rj * 256 + ci + 1];
    endfunction

    // Position along one axis, offset from the origin by the chosen cell and fraction divided by inv.
    function automatic logic [31:0] aim(input logic [31:0] org, input logic [31:0] inv,
                                        input int slot, input logic [15:0] frac);
        longint unsigned num;
        if (inv == 0) return org + $urandom_range(0, 65535);
        if (slot < 0) return org - $urandom_range(1, 65536);
        num = (longint'(slot) << 32) | (longint'(frac) << 16);
        return org + 32'(num / longint'({32'b0, inv}));
    endfunction

    function automatic int region(input int unsigned count);
        int unsigned c;
        c = (count > 256) ? 256 : count;
        return (c < 2) ? 2 : ((c > 12) ? 12 : c);
    endfunction

    function automatic int pick_cell(input int unsigned count);
        int unsigned c;
        c = (count > 256) ? 256 : count;
        case ($urandom_range(0, 9))
            0: return -1;
            1: return int'(c) - 1;
            2: return int'(c) - 2;
            default: return $urandom_range(0, region(count) - 2);
        endcase
    endfunction

    task automatic random_evaluate();
        logic [31:0] qx, qy;
        int          tries;
        for (tries = 0; tries < 8; tries++) begin
            if ($urandom_range(0, 6) == 0) begin
                qx = $urandom;
                qy = $urandom;
            end else begin
                qx = aim(cfg_ox, cfg_ix, pick_cell(cfg_cols), 16'($urandom));
                qy = aim(cfg_oy, cfg_iy, pick_cell(cfg_rows), 16'($urandom));
            end
            if (safe_query(qx, qy)) break;
        end
        // The origin maps to the preloaded corner cell, or lies outside when an axis has under two cells.
        if (!safe_query(qx, qy)) begin
            qx = cfg_ox;
            qy = cfg_oy;
        end
        evaluate_at(qx, qy);
    endtask

    task automatic write_register(input gbg_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] ox, input logic [31:0] oy,
                                  input logic [31:0] ix, input logic [31:0] iy,
                                  input int unsigned nc, input int unsigned nr);
        // Settings only change once the pipeline has drained. The wait for an empty queue
        // starts only once the checker has already counted the last transfer.
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (12) @(posedge i_clk);
        write_register(gbg_pkg::REG_ORIGIN_X, ox);
        write_register(gbg_pkg::REG_ORIGIN_Y, oy);
        write_register(gbg_pkg::REG_INV_X, ix);
        write_register(gbg_pkg::REG_INV_Y, iy);
        write_register(gbg_pkg::REG_COLUMNS, nc);
        write_register(gbg_pkg::REG_ROWS, nr);
        cfg_ox = ox;
        cfg_oy = oy;
        cfg_ix = ix;
        cfg_iy = iy;
        cfg_cols = nc & 9'h1FF;
        cfg_rows = nr & 9'h1FF;
    endtask

    initial begin
        int item;
        int phase;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                1: apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 2, 2);
                2: apply_settings(0, 0, 0, 0, 256, 256);
                3: apply_settings($urandom, $urandom, 32'd65536, 32'd32768, 0, 1);
                4: apply_settings($urandom_range(0, 1 << 20), $urandom, 32'h0010_0000,
                                  32'h0000_1000, 511, 300);
                5: apply_settings(32'hFFFB_0000, 32'h0003_0000, 32'd21845, 32'd98304, 9, 5);
                6: apply_settings(0, 0, 32'd65536, 32'd65536, 256, 256);
                default: ;
            endcase

            // Fill the corner region that targeted queries aim at.
            for (int r = 0; r < region(cfg_rows); r++)
                for (int c = 0; c < region(cfg_cols); c++)
                    load_sample(8'(c), 8'(r), pick_sample());

            if (phase == 0) begin
                // Extreme samples at the corner cell and at the far edge of the grid.
                load_sample(0, 0, 32'h7FFF_FFFF);
                load_sample(0, 1, 32'h8000_0000);
                load_sample(1, 1, 32'h7FFF_FFFF);
                load_sample(1, 0, 32'h8000_0000);
                load_sample(254, 0, 32'h8000_0000);
                load_sample(255, 0, 32'h7FFF_FFFF);
                load_sample(254, 1, 32'h0001_0000);
                load_sample(255, 1, 32'hFFFF_0000);
                load_sample(255, 255, 32'h1234_5678);
                evaluate_at(32'h0000_0000, 32'h0000_0000);
                evaluate_at(32'h0000_FFFF, 32'h0000_FFFF);
                evaluate_at(32'h0000_8000, 32'h0000_8000);
                evaluate_at(32'h0000_FFFF, 32'h0000_0000);
                evaluate_at(32'hFFFF_FFFF, 32'h0000_0000);
                evaluate_at(32'h0000_0000, 32'hFFFF_FFFF);
                evaluate_at(32'h00FE_8000, 32'h0000_4000);
                evaluate_at(32'h00FF_0000, 32'h0000_0000);
                evaluate_at(32'h7FFF_FFFF, 32'h8000_0000);
                evaluate_at(32'h8000_0000, 32'h7FFF_FFFF);
                evaluate_at(32'h0000_0000, 32'h00FF_0000);
            end

            for (item = 0; item < RANDOM_PER_PHASE; item++) begin
                if (item % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 35) begin
                    if ($urandom_range(0, 1) == 0)
                        load_sample(8'($urandom_range(0, region(cfg_cols) - 1)),
                                    8'($urandom_range(0, region(cfg_rows) - 1)),
                                    pick_sample());
                    else
                        load_sample(8'($urandom), 8'($urandom), pick_sample());
                end else begin
                    random_evaluate();
                end
            end
        end

        // Let every outstanding result arrive, then allow for the pipeline depth.
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("** grid_bilinear_gradient_unit: PASSED **");
        end else begin
            $display("** grid_bilinear_gradient_unit: FAILED **");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/gbg_pkg.sv
hdl/gbg_locate.sv
hdl/gbg_bank.sv
hdl/grid_bilinear_gradient_unit.sv
bench/grid_bilinear_gradient_checker.sv
bench/grid_bilinear_gradient_unit_test.sv
